// ===== src/http3_settings_payload_parser_assert.svh =====
// Assertion macros for the settings payload parser core.
`ifndef HTTP3_SETTINGS_PAYLOAD_PARSER_ASSERT_SVH
`define HTTP3_SETTINGS_PAYLOAD_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/hspp_pkg.sv =====
// Types and constants shared by the settings payload parser modules.
package hspp_pkg;

    localparam int ID_REGS    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ID_W       = 16;
    localparam int VALUE_W    = 62;
    localparam int COUNT_W    = 10;
    localparam int IN_DEPTH   = 2;
    localparam int OUT_DEPTH  = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SETTINGS_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_ID_A      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_ID_B      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_ID_C      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_ID_D      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_ID_ENABLE = 3'd5;

    // Frame status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_LOAD  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    // Register reset values.
    localparam logic [COUNT_W-1:0] SETTINGS_LIMIT_RST  = 10'd16;
    localparam logic [ID_REGS-1:0] KNOWN_ID_ENABLE_RST = 4'b0111;
    localparam logic [ID_W-1:0]    KNOWN_ID_RST [ID_REGS] = '{16'd1, 16'd6, 16'd7, 16'd0};

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic               pair_valid;
        logic [ID_W-1:0]    setting_id;
        logic [VALUE_W-1:0] setting_value;
        logic               frame_done;
        logic [1:0]         frame_status;
    } t_out_item;

    typedef struct packed {
        logic [COUNT_W-1:0] settings_limit;
        logic [ID_REGS-1:0] known_id_enable;
    } t_cfg;

endpackage

// ===== src/http3_settings_payload_parser.sv =====
// Top level of the settings payload parser: configuration registers and the queues.
// A pushed byte is registered in the input queue, and its result in the output queue.
// Throughput: one payload byte per cycle, sustained while results are popped.
// The input queue and the output queue hold two transactions each, so either side may stall.
// Reset is synchronous and active low; it clears the queues, the frame state and
// restores the registers to 16, 1, 6, 7, 0 and enable 0111.
module http3_settings_payload_parser #(
    parameter int KNOWN_IDS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  hspp_pkg::t_in_item                 i_in_item,
    output logic                               empty,
    input  logic                               pop,
    output hspp_pkg::t_out_item                o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hspp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hspp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Identifier registers beyond the four that exist never match.
    localparam int NUM_IDS = (KNOWN_IDS < hspp_pkg::ID_REGS) ? KNOWN_IDS : hspp_pkg::ID_REGS;

    logic [hspp_pkg::COUNT_W-1:0] r_settings_limit;
    logic [hspp_pkg::ID_REGS-1:0] r_known_id_enable;
    logic [hspp_pkg::ID_W-1:0]    r_known_id [NUM_IDS];

    hspp_pkg::t_cfg      w_cfg;
    hspp_pkg::t_in_item  w_head;
    hspp_pkg::t_out_item w_result;
    logic                w_in_empty;
    logic                w_in_pop;
    logic                w_out_full;
    logic                w_out_push;

    assign o_cfg_ready           = 1'b1;
    assign w_cfg.settings_limit  = r_settings_limit;
    assign w_cfg.known_id_enable = r_known_id_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settings_limit  <= hspp_pkg::SETTINGS_LIMIT_RST;
            r_known_id_enable <= hspp_pkg::KNOWN_ID_ENABLE_RST;
            for (int k = 0; k < NUM_IDS; k++) begin
                r_known_id[k] <= hspp_pkg::KNOWN_ID_RST[k];
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == hspp_pkg::CFG_SETTINGS_LIMIT) begin
                r_settings_limit <= i_cfg_data[hspp_pkg::COUNT_W-1:0];
            end
            if (i_cfg_index == hspp_pkg::CFG_KNOWN_ID_ENABLE) begin
                r_known_id_enable <= i_cfg_data[hspp_pkg::ID_REGS-1:0];
            end
            for (int k = 0; k < NUM_IDS; k++) begin
                if (i_cfg_index == hspp_pkg::CFG_IDX_W'(hspp_pkg::CFG_KNOWN_ID_A + k)) begin
                    r_known_id[k] <= i_cfg_data;
                end
            end
        end
    end

    hspp_fifo #(
        .WIDTH ($bits(hspp_pkg::t_in_item)),
        .DEPTH (hspp_pkg::IN_DEPTH)
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_in_item),
        .o_full  (full),
        .i_pop   (w_in_pop),
        .o_data  (w_head),
        .o_empty (w_in_empty)
    );

    hspp_core #(
        .NUM_IDS (NUM_IDS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_empty (w_in_empty),
        .i_in_item  (w_head),
        .o_in_pop   (w_in_pop),
        .i_out_full (w_out_full),
        .o_out_push (w_out_push),
        .o_out_item (w_result),
        .i_cfg      (w_cfg),
        .i_known_id (r_known_id)
    );

    hspp_fifo #(
        .WIDTH ($bits(hspp_pkg::t_out_item)),
        .DEPTH (hspp_pkg::OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_result),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );

endmodule

// ===== src/hspp_fifo.sv =====
// Small register queue used on both sides of the parser core.
module hspp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    // DEPTH must be a power of two of at least two, so the pointers wrap by themselves; the block does not check it.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/hspp_core.sv =====
// Parser core: variable-length integer decoding, pair matching and frame status.
module hspp_core #(
    parameter int NUM_IDS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_empty,
    input  hspp_pkg::t_in_item    i_in_item,
    output logic                  o_in_pop,
    input  logic                  i_out_full,
    output logic                  o_out_push,
    output hspp_pkg::t_out_item   o_out_item,
    input  hspp_pkg::t_cfg        i_cfg,
    input  logic [hspp_pkg::ID_W-1:0] i_known_id [NUM_IDS]
);

    logic                           r_in_value_phase;
    logic [2:0]                     r_bytes_left;
    logic [hspp_pkg::VALUE_W-1:0]   r_acc;
    logic [hspp_pkg::ID_W-1:0]      r_held_id;
    logic [hspp_pkg::COUNT_W-1:0]   r_accepted_count;
    logic [1:0]                     r_error_status;

    logic                           n_in_value_phase;
    logic [2:0]                     n_bytes_left;
    logic [hspp_pkg::VALUE_W-1:0]   n_acc;
    logic [hspp_pkg::ID_W-1:0]      n_held_id;
    logic [hspp_pkg::COUNT_W-1:0]   n_accepted_count;
    logic [1:0]                     n_error_status;

    logic       w_consume;
    logic       w_last;
    logic [7:0] w_byte;
    logic       w_known;
    logic       w_start_ok;
    logic       w_pair;

    assign w_consume = !i_in_empty && !i_out_full;
    assign w_last    = i_in_item.last_byte;
    assign w_byte    = i_in_item.payload_byte;
    assign o_in_pop  = w_consume;

    always_comb begin
        w_known = 1'b0;
        for (int i = 0; i < NUM_IDS; i++) begin
            if (i_cfg.known_id_enable[i] && (i_known_id[i] == r_held_id)) begin
                w_known = 1'b1;
            end
        end
    end

    always_comb begin
        n_in_value_phase = r_in_value_phase;
        n_bytes_left     = r_bytes_left;
        n_acc            = r_acc;
        n_held_id        = r_held_id;
        n_accepted_count = r_accepted_count;
        n_error_status   = r_error_status;
        w_start_ok       = 1'b1;
        w_pair           = 1'b0;

        if (r_error_status == hspp_pkg::STATUS_OK) begin
            if (r_bytes_left == 3'd0) begin
                // A new identifier may not begin once the limit is reached.
                if (!r_in_value_phase && (r_accepted_count >= i_cfg.settings_limit)) begin
                    n_error_status = hspp_pkg::STATUS_LOAD;
                    w_start_ok     = 1'b0;
                end else begin
                    n_bytes_left = 3'((4'd1 << w_byte[7:6]) - 4'd1);
                    n_acc        = {56'd0, w_byte[5:0]};
                end
            end else begin
                n_acc        = {r_acc[hspp_pkg::VALUE_W-9:0], w_byte};
                n_bytes_left = r_bytes_left - 3'd1;
            end

            if (w_start_ok && (n_bytes_left == 3'd0)) begin
                if (!r_in_value_phase) begin
                    n_held_id        = n_acc[hspp_pkg::ID_W-1:0];
                    n_in_value_phase = 1'b1;
                end else begin
                    n_in_value_phase = 1'b0;
                    if (w_known) begin
                        w_pair = 1'b1;
                        if (r_accepted_count != '1) begin
                            n_accepted_count = r_accepted_count + 10'd1;
                        end
                    end
                end
            end

            if (w_last && (n_error_status == hspp_pkg::STATUS_OK)
                    && (n_in_value_phase || (n_bytes_left != 3'd0))) begin
                n_error_status = hspp_pkg::STATUS_ERROR;
            end
        end

        o_out_item.pair_valid    = w_pair;
        o_out_item.setting_id    = w_pair ? r_held_id : '0;
        o_out_item.setting_value = w_pair ? n_acc : '0;
        o_out_item.frame_done    = w_last;
        o_out_item.frame_status  = w_last ? n_error_status : hspp_pkg::STATUS_OK;

        // The last byte closes the frame and the per-frame state starts afresh.
        if (w_last) begin
            n_in_value_phase = 1'b0;
            n_bytes_left     = 3'd0;
            n_acc            = '0;
            n_held_id        = '0;
            n_accepted_count = '0;
            n_error_status   = hspp_pkg::STATUS_OK;
        end
    end

    assign o_out_push = w_consume && (w_pair || w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_value_phase <= 1'b0;
            r_bytes_left     <= 3'd0;
            r_acc            <= '0;
            r_held_id        <= '0;
            r_accepted_count <= '0;
            r_error_status   <= hspp_pkg::STATUS_OK;
        end else if (w_consume) begin
            r_in_value_phase <= n_in_value_phase;
            r_bytes_left     <= n_bytes_left;
            r_acc            <= n_acc;
            r_held_id        <= n_held_id;
            r_accepted_count <= n_accepted_count;
            r_error_status   <= n_error_status;
        end
    end

`include "http3_settings_payload_parser_assert.svh"

    `HSPP_ASSERT_NOW(a_push_has_room, o_out_push, !i_out_full, "result pushed into a full queue")
    `HSPP_ASSERT_NOW(a_pair_needs_ok, w_pair, r_error_status == hspp_pkg::STATUS_OK, "pair emitted after an error")
    `HSPP_ASSERT_NEXT(a_error_sticky, (r_error_status != hspp_pkg::STATUS_OK) && !(w_consume && w_last), r_error_status == $past(r_error_status), "error status changed inside a frame")
    `HSPP_ASSERT_NEXT(a_frame_clears, w_consume && w_last, (r_accepted_count == '0) && !r_in_value_phase && (r_bytes_left == 3'd0), "frame state not cleared after last byte")

endmodule

// ===== verif/http3_settings_checker.sv =====
// Checker for the settings payload parser: predicts every result and compares it with the block's.
`timescale 1ns / 1ps
module http3_settings_checker #(
    parameter int KNOWN_IDS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic                               i_full,
    input  hspp_pkg::t_in_item                 i_in_item,
    input  logic                               i_empty,
    input  logic                               i_pop,
    input  hspp_pkg::t_out_item                i_out_item,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [hspp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hspp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import hspp_pkg::*;

    // Register copies.
    logic [COUNT_W-1:0] limit_reg;
    logic [ID_W-1:0]    id_reg [ID_REGS];
    logic [ID_REGS-1:0] id_enable;

    // Frame state.
    logic               value_phase;
    logic [3:0]         bytes_to_go;
    logic [VALUE_W-1:0] varint_acc;
    logic [ID_W-1:0]    pair_id;
    logic [COUNT_W-1:0] pairs_taken;
    logic [1:0]         frame_err;

    t_out_item expected_results[$];
    int        mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic id_recognised(input logic [ID_W-1:0] id);
        logic hit;
        int   i;
        hit = 1'b0;
        for (i = 0; i < KNOWN_IDS && i < ID_REGS; i++) begin
            if (id_enable[i] && id_reg[i] == id) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    task automatic clear_frame();
        value_phase = 1'b0;
        bytes_to_go = '0;
        varint_acc  = '0;
        pair_id     = '0;
        pairs_taken = '0;
        frame_err   = STATUS_OK;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SETTINGS_LIMIT: begin
                limit_reg = data[COUNT_W-1:0];
            end
            CFG_KNOWN_ID_A: begin
                id_reg[0] = data[ID_W-1:0];
            end
            CFG_KNOWN_ID_B: begin
                id_reg[1] = data[ID_W-1:0];
            end
            CFG_KNOWN_ID_C: begin
                id_reg[2] = data[ID_W-1:0];
            end
            CFG_KNOWN_ID_D: begin
                id_reg[3] = data[ID_W-1:0];
            end
            CFG_KNOWN_ID_ENABLE: begin
                id_enable = data[ID_REGS-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // Advances the frame state by one payload byte and queues the result it causes, if any.
    task automatic parse_byte(input t_in_item item);
        logic      start_ok;
        logic      pair_seen;
        t_out_item res;
        pair_seen = 1'b0;
        res       = '0;
        if (frame_err == STATUS_OK) begin
            start_ok = 1'b1;
            if (bytes_to_go == 0) begin
                // A new identifier may not begin once the limit has been reached.
                if (!value_phase && pairs_taken >= limit_reg) begin
                    frame_err = STATUS_LOAD;
                    start_ok  = 1'b0;
                end else begin
                    bytes_to_go = (4'd1 << item.payload_byte[7:6]) - 4'd1;
                    varint_acc  = {56'd0, item.payload_byte[5:0]};
                end
            end else begin
                varint_acc  = {varint_acc[VALUE_W-9:0], item.payload_byte};
                bytes_to_go = bytes_to_go - 4'd1;
            end
            if (start_ok && bytes_to_go == 0) begin
                if (!value_phase) begin
                    pair_id     = varint_acc[ID_W-1:0];
                    value_phase = 1'b1;
                end else begin
                    value_phase = 1'b0;
                    if (id_recognised(pair_id)) begin
                        pair_seen         = 1'b1;
                        res.pair_valid    = 1'b1;
                        res.setting_id    = pair_id;
                        res.setting_value = varint_acc;
                        if (pairs_taken != '1) begin
                            pairs_taken = pairs_taken + 10'd1;
                        end
                    end
                end
            end
            if (item.last_byte && frame_err == STATUS_OK && (value_phase || bytes_to_go != 0)) begin
                frame_err = STATUS_ERROR;
            end
        end
        if (pair_seen || item.last_byte) begin
            res.frame_done   = item.last_byte;
            res.frame_status = item.last_byte ? frame_err : STATUS_OK;
            expected_results.push_back(res);
        end
        if (item.last_byte) begin
            clear_frame();
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            limit_reg = SETTINGS_LIMIT_RST;
            id_reg    = KNOWN_ID_RST;
            id_enable = KNOWN_ID_ENABLE_RST;
            clear_frame();
            expected_results.delete();
        end else begin
            // The result side is checked first: an item pushed at this edge cannot be out yet.
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %0h",
                             $time, i_out_item);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("pair_valid", 64'(want.pair_valid), 64'(i_out_item.pair_valid));
                    check_field("setting_id", 64'(want.setting_id), 64'(i_out_item.setting_id));
                    check_field("setting_value", 64'(want.setting_value),
                                64'(i_out_item.setting_value));
                    check_field("frame_done", 64'(want.frame_done), 64'(i_out_item.frame_done));
                    check_field("frame_status", 64'(want.frame_status),
                                64'(i_out_item.frame_status));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                write_register(i_cfg_index, i_cfg_data);
            end
            if (i_push && !i_full) begin
                parse_byte(i_in_item);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ===== verif/tb_http3_settings_payload_parser.sv =====
// Testbench top for the settings payload parser: reset, configuration, payload stimulus and verdict.
`timescale 1ns / 1ps
module tb_http3_settings_payload_parser;
    import hspp_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 12;
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 300;
    localparam int BYTES_PER_PHASE = 450;
    localparam int FRAMES_PER_CFG  = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    t_in_item              in_item;
    logic                  empty;
    logic                  pop;
    t_out_item             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int bytes_sent     = 0;

    // Identifiers currently programmed, so that most pairs can be aimed at them.
    logic [ID_W-1:0] id_shadow [ID_REGS];
    logic [7:0]      frame_bytes[$];

    http3_settings_payload_parser DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    http3_settings_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_item    (in_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Ends the run if no transaction of any kind completes for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    // Leaves push high on return; the caller lowers it before waiting for the block to drain.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= {b, last};
        do @(posedge clk); while (full);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        frame_bytes.delete();
    endtask

    // Waits until every expected result has been popped and the pipeline has settled.
    task automatic drain();
        push <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx >= CFG_KNOWN_ID_A && idx <= CFG_KNOWN_ID_D) begin
            id_shadow[idx - CFG_KNOWN_ID_A] = data;
        end
    endtask

    task automatic configure_random();
        logic [CFG_DATA_W-1:0] data;
        int                    i;
        case ($urandom_range(5))
            0: data = 16'd0;
            1: data = 16'd1;
            2: data = 16'($urandom_range(6, 2));
            3: data = 16'd1023;
            4: data = 16'($urandom_range(1023));
            default: data = 16'd16;
        endcase
        write_reg(CFG_SETTINGS_LIMIT, data);
        for (i = 0; i < ID_REGS; i++) begin
            case ($urandom_range(4))
                0: data = 16'h0000;
                1: data = 16'hFFFF;
                4: data = 16'($urandom);
                default: data = 16'($urandom_range(63));
            endcase
            write_reg(CFG_KNOWN_ID_A + CFG_IDX_W'(i), data);
        end
        case ($urandom_range(5))
            0: data = 16'h0;
            1, 2: data = 16'hF;
            default: data = 16'($urandom_range(15));
        endcase
        write_reg(CFG_KNOWN_ID_ENABLE, data);
        cfg_valid <= 1'b0;
    endtask

    // Appends a variable-length integer of 1 << code bytes; bits that do not fit are dropped.
    task automatic add_varint(input logic [63:0] raw, input int code);
        int          nbytes;
        int          k;
        logic [63:0] word;
        nbytes = 1 << code;
        word   = raw & ((64'd1 << (8 * nbytes - 2)) - 64'd1);
        word   = word | (64'(code) << (8 * nbytes - 2));
        for (k = nbytes - 1; k >= 0; k--) begin
            frame_bytes.push_back(word[8 * k +: 8]);
        end
    endtask

    task automatic add_pair();
        logic [ID_W-1:0] id;
        logic [63:0]     raw;
        int              shortest;
        if ($urandom_range(9) < 7) begin
            id = id_shadow[$urandom_range(ID_REGS - 1)];
        end else begin
            id = 16'($urandom);
        end
        shortest = (id < 64) ? 0 : (id < 16384) ? 1 : 2;
        raw = {$urandom, $urandom};
        raw[ID_W-1:0] = id;
        add_varint(raw, $urandom_range(3, shortest));
        case ($urandom_range(5))
            0: raw = '0;
            1: raw = '1;
            default: raw = {$urandom, $urandom};
        endcase
        add_varint(raw, $urandom_range(3));
    endtask

    task automatic random_frame();
        int kind;
        int cut;
        kind = $urandom_range(99);
        repeat ($urandom_range(5)) add_pair();
        if (kind < 70) begin
            if (frame_bytes.size() == 0) begin
                add_pair();
            end
        end else if (kind < 90) begin
            // Cut the final pair short, inside its identifier or its value.
            cut = frame_bytes.size();
            add_pair();
            repeat ($urandom_range(frame_bytes.size() - cut - 1, 1)) void'(frame_bytes.pop_back());
        end else begin
            repeat ($urandom_range(12, 1)) frame_bytes.push_back(8'($urandom));
        end
        send_frame();
    endtask

    task automatic directed_frames();
        // Two known pairs, the second with the largest 8-byte value, completing on the last byte.
        frame_bytes = '{8'h01, 8'h00, 8'h06, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                        8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
        // Identifier 0 is programmed but not enabled, so the pair is dropped.
        frame_bytes = '{8'h00, 8'h3F};
        send_frame();
        // Frame ends inside a 2-byte identifier.
        frame_bytes = '{8'h40};
        send_frame();
        // Frame ends straight after an identifier.
        frame_bytes = '{8'h07};
        send_frame();
        // Frame ends inside a 2-byte value.
        frame_bytes = '{8'h07, 8'h40};
        send_frame();
        // Limit lowered in the middle of a frame: the next identifier trips excessive load
        // and the rest of the frame is ignored.
        send_byte(8'h01, 1'b0);
        send_byte(8'h05, 1'b0);
        drain();
        write_reg(CFG_SETTINGS_LIMIT, 16'd1);
        cfg_valid <= 1'b0;
        frame_bytes = '{8'h06, 8'h00, 8'hFF};
        send_frame();
        drain();
        write_reg(CFG_SETTINGS_LIMIT, 16'd0);
        write_reg(CFG_KNOWN_ID_D, 16'hFFFF);
        write_reg(CFG_KNOWN_ID_ENABLE, 16'hF);
        cfg_valid <= 1'b0;
        frame_bytes = '{8'h00};
        send_frame();
        drain();
        write_reg(CFG_SETTINGS_LIMIT, 16'd1023);
        cfg_valid <= 1'b0;
        // Largest identifier in a 4-byte encoding.
        frame_bytes = '{8'h80, 8'h00, 8'hFF, 8'hFF, 8'h00};
        send_frame();
        drain();
        write_reg(CFG_KNOWN_ID_A, 16'h0000);
        write_reg(CFG_KNOWN_ID_ENABLE, 16'h0);
        cfg_valid <= 1'b0;
        frame_bytes = '{8'h01, 8'h00};
        send_frame();
    endtask

    initial begin
        int phase;
        int frames;
        rst_n     = 1'b0;
        push      = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        id_shadow = KNOWN_ID_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_frames();
        drain();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 52;
                end
                default: begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
            endcase
            configure_random();
            // The result side holds off while bytes keep coming, so both queues fill up.
            if (phase == 0) begin
                hold_request = HOLD_CYCLES;
            end
            frames     = 0;
            bytes_sent = 0;
            while (bytes_sent < BYTES_PER_PHASE) begin
                random_frame();
                frames++;
                if (frames % FRAMES_PER_CFG == 0) begin
                    drain();
                    configure_random();
                end
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/hspp_pkg.sv
src/hspp_fifo.sv
src/hspp_core.sv
src/http3_settings_payload_parser.sv
verif/http3_settings_checker.sv
verif/tb_http3_settings_payload_parser.sv
